[hdl/mtm_pkg.sv]
`timescale 1ns / 1ps

package mtm_pkg;

	localparam int TILE    = 8;
	localparam int K_MAX   = 256;
	localparam int ELEM_W  = 16;
	localparam int MUL_W   = 2 * ELEM_W;
	localparam int PROD_W  = 40;
	localparam int ADDR_W  = $clog2(TILE * K_MAX);
	localparam int CNT_W   = ADDR_W + 1;
	localparam int KLEN_W  = $clog2(K_MAX) + 1;
	localparam int TILE_W  = $clog2(TILE) + 1;
	localparam int IDX_W   = $clog2(TILE);
	localparam int CFG_W   = KLEN_W;
	localparam int CFGI_W  = 2;

	typedef enum logic [CFGI_W-1:0] {
		REG_INNER_LEN = 2'd0,
		REG_ROWS_USED = 2'd1,
		REG_COLS_USED = 2'd2,
		REG_NONE      = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic              wr_a;
		logic              wr_b;
		logic [ADDR_W-1:0] addr;
	} load_cmd_t;

	typedef struct packed {
		logic              issue;
		logic              first;
		logic              last;
		logic              tile_last;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [ADDR_W-1:0] a_addr;
		logic [ADDR_W-1:0] b_addr;
	} mac_cmd_t;

	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic              tile_last;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
	} mac_tag_t;

	typedef struct packed {
		logic res_done;
		logic out_full;
	} dp_status_t;

	function automatic logic [KLEN_W-1:0] clamp_inner(input logic [KLEN_W-1:0] v);
		logic [KLEN_W-1:0] r;
		if (v == '0) begin
			r = KLEN_W'(1);
		end else if (v > KLEN_W'(K_MAX)) begin
			r = KLEN_W'(K_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [TILE_W-1:0] clamp_tile(input logic [TILE_W-1:0] v);
		logic [TILE_W-1:0] r;
		if (v == '0) begin
			r = TILE_W'(1);
		end else if (v > TILE_W'(TILE)) begin
			r = TILE_W'(TILE);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[hdl/matrix_tile_multiply_top.sv]
// flow: the beat that completes the b tile starts the dot products; each
// result entry runs one mac per cycle through read, multiply, accumulate and
// output register, and the next entry starts once it is taken.
// throughput: one element per cycle while loading, then compute; no new element
// is taken until the last entry of the tile has been taken.
// reset: async active low, clears controller, mac tags and output valid; stores and data regs kept
`timescale 1ns / 1ps

module matrix_tile_multiply_top
	import mtm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFGI_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [ELEM_W-1:0] element,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [PROD_W-1:0] product_value,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic                     tile_last
);

	load_cmd_t  load;
	mac_cmd_t   cmd;
	dp_status_t status;

	mtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.load      (load),
		.cmd       (cmd),
		.status    (status)
	);

	mtm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.element       (element),
		.cmd           (cmd),
		.status        (status),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.product_value (product_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.tile_last     (tile_last)
	);

endmodule

[hdl/mtm_ctrl.sv]
`timescale 1ns / 1ps

module mtm_ctrl
	import mtm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFGI_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	output load_cmd_t            load,
	output mac_cmd_t             cmd,
	input  dp_status_t           status
);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	state_t              state_q;
	logic [KLEN_W-1:0]   inner_q;
	logic [TILE_W-1:0]   rows_q;
	logic [TILE_W-1:0]   cols_q;
	logic [CNT_W-1:0]    idx_q;
	logic                phase_b_q;
	logic [KLEN_W-1:0]   k_q;
	logic [IDX_W-1:0]    row_q;
	logic [IDX_W-1:0]    col_q;
	logic [ADDR_W-1:0]   a_base_q;
	logic [ADDR_W-1:0]   a_ptr_q;
	logic [ADDR_W-1:0]   b_ptr_q;

	logic [CNT_W:0]      n_a_full;
	logic [CNT_W:0]      n_b_full;
	logic [CNT_W-1:0]    n_a;
	logic [CNT_W-1:0]    n_b;
	logic [CNT_W-1:0]    idx_next;
	logic                accept;
	logic                k_last;
	logic                row_last;
	logic                col_last;
	logic [ADDR_W-1:0]   a_base_next;

	assign n_a_full    = {{(CNT_W+1-TILE_W){1'b0}}, rows_q} * {{(CNT_W+1-KLEN_W){1'b0}}, inner_q};
	assign n_b_full    = {{(CNT_W+1-TILE_W){1'b0}}, cols_q} * {{(CNT_W+1-KLEN_W){1'b0}}, inner_q};
	assign n_a         = n_a_full[CNT_W-1:0];
	assign n_b         = n_b_full[CNT_W-1:0];
	assign idx_next    = idx_q + CNT_W'(1);
	assign in_stall    = (state_q != ST_LOAD);
	assign accept      = in_valid && !in_stall;
	assign k_last      = (k_q == inner_q - KLEN_W'(1));
	assign row_last    = ({1'b0, row_q} == rows_q - TILE_W'(1));
	assign col_last    = ({1'b0, col_q} == cols_q - TILE_W'(1));
	assign a_base_next = a_base_q + ADDR_W'(inner_q);

	assign load.wr_a = accept && !phase_b_q;
	assign load.wr_b = accept && phase_b_q;
	assign load.addr = idx_q[ADDR_W-1:0];

	assign cmd.issue     = (state_q == ST_ISSUE);
	assign cmd.first     = (k_q == '0);
	assign cmd.last      = k_last;
	assign cmd.tile_last = row_last && col_last;
	assign cmd.row       = row_q;
	assign cmd.col       = col_q;
	assign cmd.a_addr    = a_ptr_q;
	assign cmd.b_addr    = b_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			inner_q   <= KLEN_W'(K_MAX);
			rows_q    <= TILE_W'(TILE);
			cols_q    <= TILE_W'(TILE);
			idx_q     <= '0;
			phase_b_q <= 1'b0;
			k_q       <= '0;
			row_q     <= '0;
			col_q     <= '0;
			a_base_q  <= '0;
			a_ptr_q   <= '0;
			b_ptr_q   <= '0;
		end else begin
			if (cfg_we && (cfg_index != REG_NONE)) begin
				unique case (reg_index_t'(cfg_index))
					REG_INNER_LEN: inner_q <= clamp_inner(cfg_data);
					REG_ROWS_USED: rows_q  <= clamp_tile(cfg_data[TILE_W-1:0]);
					REG_COLS_USED: cols_q  <= clamp_tile(cfg_data[TILE_W-1:0]);
					default: ;
				endcase
				idx_q     <= '0;
				phase_b_q <= 1'b0;
			end else begin
				unique case (state_q)
					ST_LOAD: begin
						if (accept) begin
							if (!phase_b_q) begin
								if (idx_next == n_a) begin
									idx_q     <= '0;
									phase_b_q <= 1'b1;
								end else begin
									idx_q <= idx_next;
								end
							end else begin
								if (idx_next == n_b) begin
									idx_q     <= '0;
									phase_b_q <= 1'b0;
									state_q   <= ST_ISSUE;
								end else begin
									idx_q <= idx_next;
								end
							end
						end
					end
					ST_ISSUE: begin
						a_ptr_q <= a_ptr_q + ADDR_W'(1);
						b_ptr_q <= b_ptr_q + ADDR_W'(1);
						if (k_last) begin
							k_q     <= '0;
							state_q <= ST_DRAIN;
						end else begin
							k_q <= k_q + KLEN_W'(1);
						end
					end
					ST_DRAIN: begin
						if (status.res_done) begin
							state_q <= ST_HOLD;
						end
					end
					ST_HOLD: begin
						if (!status.out_full) begin
							if (row_last && col_last) begin
								row_q    <= '0;
								col_q    <= '0;
								a_base_q <= '0;
								a_ptr_q  <= '0;
								b_ptr_q  <= '0;
								state_q  <= ST_LOAD;
							end else if (col_last) begin
								col_q    <= '0;
								row_q    <= row_q + IDX_W'(1);
								a_base_q <= a_base_next;
								a_ptr_q  <= a_base_next;
								b_ptr_q  <= '0;
								state_q  <= ST_ISSUE;
							end else begin
								col_q   <= col_q + IDX_W'(1);
								a_ptr_q <= a_base_q;
								state_q <= ST_ISSUE;
							end
						end
					end
					default: state_q <= ST_LOAD;
				endcase
			end
		end
	end

	// reads stay inside the part of the store loaded for this tile
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> ({1'b0, cmd.a_addr} < n_a) && ({1'b0, cmd.b_addr} < n_b))
		else $error("mac read outside loaded tile");

	assert property (@(posedge clk) disable iff (!arst_n)
		status.res_done |-> (state_q == ST_DRAIN))
		else $error("result landed outside drain");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) && k_last |=> (state_q == ST_DRAIN) && !cmd.issue)
		else $error("dot product issue did not stop at inner length");

endmodule

[hdl/mtm_datapath.sv]
`timescale 1ns / 1ps

module mtm_datapath
	import mtm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  load_cmd_t                load,
	input  logic signed [ELEM_W-1:0] element,
	input  mac_cmd_t                 cmd,
	output dp_status_t               status,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic signed [PROD_W-1:0] product_value,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic                     tile_last
);

	localparam int DEPTH = TILE * K_MAX;

	logic [ELEM_W-1:0]        a_mem [DEPTH];
	logic [ELEM_W-1:0]        b_mem [DEPTH];

	logic signed [ELEM_W-1:0] a_rd_s1;
	logic signed [ELEM_W-1:0] b_rd_s1;
	mac_tag_t                 tag_s1;
	logic signed [MUL_W-1:0]  mul_s2;
	mac_tag_t                 tag_s2;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] sum;
	logic                     out_valid_q;
	logic signed [PROD_W-1:0] value_q;
	logic [IDX_W-1:0]         row_q;
	logic [IDX_W-1:0]         col_q;
	logic                     last_q;
	logic                     landing;

	// tile stores, one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (load.wr_a) begin
			a_mem[load.addr] <= element;
		end
		a_rd_s1 <= a_mem[cmd.a_addr];
	end

	always_ff @(posedge clk) begin
		if (load.wr_b) begin
			b_mem[load.addr] <= element;
		end
		b_rd_s1 <= b_mem[cmd.b_addr];
	end

	always_ff @(posedge clk) begin
		mul_s2 <= a_rd_s1 * b_rd_s1;
	end

	assign sum     = (tag_s2.first ? '0 : acc_q) + PROD_W'(mul_s2);
	assign landing = tag_s2.valid && tag_s2.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1.valid     <= cmd.issue;
			tag_s1.first     <= cmd.first;
			tag_s1.last      <= cmd.last;
			tag_s1.tile_last <= cmd.tile_last;
			tag_s1.row       <= cmd.row;
			tag_s1.col       <= cmd.col;
			tag_s2           <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s2.valid) begin
			acc_q <= sum;
		end
		if (landing) begin
			value_q <= sum;
			row_q   <= tag_s2.row;
			col_q   <= tag_s2.col;
			last_q  <= tag_s2.tile_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (landing) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.res_done = landing;
	assign status.out_full = out_valid_q;

	assign out_valid     = out_valid_q;
	assign product_value = value_q;
	assign out_row       = row_q;
	assign out_col       = col_q;
	assign tile_last     = last_q;

	// a finished dot product never lands on an untaken beat
	assert property (@(posedge clk) disable iff (!arst_n)
		landing |-> !out_valid_q)
		else $error("result register overwritten");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(landing))
		else $error("output beat without a finished dot product");

	assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid |=> tag_s2.valid)
		else $error("mac tag lost between read and multiply");

endmodule

[tb/tile_product_checker.sv]
`timescale 1ns / 1ps

module tile_product_checker
	import mtm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFGI_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [ELEM_W-1:0] element,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [PROD_W-1:0] product_value,
	input  logic [IDX_W-1:0]         out_row,
	input  logic [IDX_W-1:0]         out_col,
	input  logic                     tile_last,
	output int                       mismatch_count,
	output int                       pending_count
);

	localparam int DEPTH = TILE * K_MAX;

	typedef struct {
		logic signed [PROD_W-1:0] value;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic                     last;
	} product_t;

	logic [ELEM_W-1:0] a_rows [DEPTH];
	logic [ELEM_W-1:0] b_cols [DEPTH];
	logic [KLEN_W-1:0] inner_len;
	logic [TILE_W-1:0] rows_used;
	logic [TILE_W-1:0] cols_used;
	int unsigned       loaded;
	product_t          products_due [$];

	function automatic int unsigned bounded(int unsigned v, int unsigned hi);
		if (v == 0) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	task automatic take_register(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] v);
		case (idx)
			REG_INNER_LEN: begin
				inner_len = v[KLEN_W-1:0];
			end
			REG_ROWS_USED: begin
				rows_used = v[TILE_W-1:0];
			end
			REG_COLS_USED: begin
				cols_used = v[TILE_W-1:0];
			end
			default: begin
				return;
			end
		endcase
		loaded = 0;
	endtask

	task automatic take_element(logic [ELEM_W-1:0] e);
		int unsigned k_len, rows, cols, n_a, total, r, c, k;
		longint      acc;
		product_t    p;
		k_len = bounded(inner_len, K_MAX);
		rows  = bounded(rows_used, TILE);
		cols  = bounded(cols_used, TILE);
		n_a   = rows * k_len;
		total = n_a + cols * k_len;
		if (loaded >= total) begin
			loaded = 0;
		end
		if (loaded < n_a) begin
			a_rows[loaded % DEPTH] = e;
		end else begin
			b_cols[(loaded - n_a) % DEPTH] = e;
		end
		loaded++;
		if (loaded == total) begin
			loaded = 0;
			for (r = 0; r < rows; r++) begin
				for (c = 0; c < cols; c++) begin
					acc = 0;
					for (k = 0; k < k_len; k++) begin
						acc += longint'($signed(a_rows[(r * k_len + k) % DEPTH]))
							* longint'($signed(b_cols[(c * k_len + k) % DEPTH]));
					end
					p.value = acc[PROD_W-1:0];
					p.row   = r[IDX_W-1:0];
					p.col   = c[IDX_W-1:0];
					p.last  = (r == rows - 1) && (c == cols - 1);
					products_due.push_back(p);
				end
			end
		end
	endtask

	task automatic check_product();
		product_t want;
		if (products_due.size() == 0) begin
			mismatch_count++;
			$display("%0t: unexpected beat, expected none, got %0d r%0d c%0d last %0b",
				$time, product_value, out_row, out_col, tile_last);
		end else begin
			want = products_due.pop_front();
			if (product_value !== want.value || out_row !== want.row
				|| out_col !== want.col || tile_last !== want.last) begin
				mismatch_count++;
				$display("%0t: expected %0d r%0d c%0d last %0b, got %0d r%0d c%0d last %0b",
					$time, want.value, want.row, want.col, want.last,
					product_value, out_row, out_col, tile_last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_len = KLEN_W'(K_MAX);
			rows_used = TILE_W'(TILE);
			cols_used = TILE_W'(TILE);
			loaded = 0;
			products_due.delete();
			mismatch_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_we) begin
				take_register(cfg_index, cfg_data);
			end
			if (in_valid && !in_stall) begin
				take_element(element);
			end
			if (out_valid && !out_stall) begin
				check_product();
			end
			pending_count = products_due.size();
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import mtm_pkg::*;

	localparam int SETTLE_CYCLES = K_MAX + 8;
	localparam int QUIET_LIMIT   = 20000;
	localparam int MODE_ITEMS    = 60;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFGI_W-1:0]        cfg_index = REG_NONE;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [ELEM_W-1:0] element = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [PROD_W-1:0] product_value;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic                     tile_last;
	int                       mismatch_count;
	int                       pending_count;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int k_now = K_MAX;
	int rows_now = TILE;
	int cols_now = TILE;
	int quiet_cycles = 0;
	int idle_plan [4] = '{0, 85, 0, 21};
	int stall_plan [4] = '{0, 0, 85, 21};
	logic signed [ELEM_W-1:0] corners [5] =
		'{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};

	matrix_tile_multiply_top uut (.*);

	tile_product_checker u_checker (.*);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int fit(int v, int hi);
		if (v == 0) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	function automatic int pick_inner();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0) begin
			return 0;
		end
		if (pick == 1) begin
			return $urandom_range(12, 7);
		end
		return $urandom_range(4, 1);
	endfunction

	function automatic int pick_tile();
		return ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
	endfunction

	function automatic logic signed [ELEM_W-1:0] random_element();
		if ($urandom_range(9) < 7) begin
			return ELEM_W'($urandom);
		end
		return corners[$urandom_range(4)];
	endfunction

	// one element beat per call, returns at the accepting edge
	task automatic push_element(input logic signed [ELEM_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		element <= v;
		do begin
			@(posedge clk);
		end while (in_stall);
	endtask

	task automatic lower_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_count != 0);
	endtask

	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(input reg_index_t idx, input int v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[CFG_W-1:0];
	endtask

	task automatic write_alone(input reg_index_t idx, input int v);
		settle();
		put_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input int k, input int r, input int c);
		settle();
		put_reg(REG_INNER_LEN, k);
		put_reg(REG_ROWS_USED, r);
		put_reg(REG_COLS_USED, c);
		@(negedge clk);
		cfg_we <= 1'b0;
		k_now = fit(k, K_MAX);
		rows_now = fit(r, TILE);
		cols_now = fit(c, TILE);
	endtask

	task automatic random_tile(output int pushed);
		int total, cut, i;
		if ($urandom_range(1) == 0) begin
			configure(pick_inner(), pick_tile(), pick_tile());
		end else if ($urandom_range(2) == 0) begin
			wait_drained();
		end
		total = (rows_now + cols_now) * k_now;
		cut = total;
		if (total > 1 && $urandom_range(7) == 0) begin
			cut = $urandom_range(total - 1, 1);
		end
		for (i = 0; i < cut; i++) begin
			push_element(random_element());
		end
		lower_valid();
		// abandoned tile, a register write restarts the load
		if (cut < total) begin
			configure(pick_inner(), pick_tile(), pick_tile());
		end
		pushed = cut;
	endtask

	initial begin
		int mode, items, pushed, i;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		configure(0, 0, 15);
		push_element(16'sh8000);
		for (i = 0; i < 8; i++) begin
			push_element(corners[i % 5]);
		end
		lower_valid();

		configure(1, 8, 8);
		for (i = 0; i < 16; i++) begin
			push_element(corners[(i * 3) % 5]);
		end
		lower_valid();

		configure(2, 2, 2);
		for (i = 0; i < 3; i++) begin
			push_element(corners[i]);
		end
		lower_valid();
		write_alone(REG_NONE, 5);
		for (i = 3; i < 8; i++) begin
			push_element(corners[i % 5]);
		end
		lower_valid();

		for (i = 0; i < 3; i++) begin
			push_element(16'sh7fff);
		end
		lower_valid();
		write_alone(REG_INNER_LEN, 2);
		for (i = 0; i < 8; i++) begin
			push_element(corners[(i + 1) % 5]);
		end
		lower_valid();

		// inner length above its bound, load dropped by the next write
		configure(511, 1, 1);
		for (i = 0; i < 12; i++) begin
			push_element(16'sh8000);
		end
		lower_valid();

		for (mode = 0; mode < 4; mode++) begin
			send_idle_pct <= idle_plan[mode];
			stall_pct <= stall_plan[mode];
			configure(pick_inner(), pick_tile(), pick_tile());
			items = 0;
			while (items < MODE_ITEMS) begin
				random_tile(pushed);
				items += pushed;
			end
		end

		settle();
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/mtm_pkg.sv
hdl/mtm_ctrl.sv
hdl/mtm_datapath.sv
hdl/matrix_tile_multiply_top.sv
tb/tile_product_checker.sv
tb/testbench.sv
